[hw/rtl/rle8_dec_pkg.sv]
// rle8_dec_pkg: shared constants and types of the rle8 bitmap decoder
// used by the channel interfaces, the parser and the top level; no dependencies

package rle8_dec_pkg;

  localparam int unsigned DIM_W      = 11;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_VALUE   = 2'd2;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(MAX_HEIGHT);
  localparam logic [PIX_W-1:0] FILL_VALUE_RST   = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] data_byte;
    logic             end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [PIX_W-1:0] fill_value;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] start_row;
    logic [DIM_W-1:0] start_col;
    logic [DIM_W-1:0] end_row;
    logic [DIM_W-1:0] end_col;
    logic [PIX_W-1:0] pixel_value;
    logic             clipped;
    logic             image_done;
  } span_t;

endpackage

[hw/rtl/rle8_dec_if.sv]
// rle8_dec channel interfaces: compressed byte input, span output, config write
// depends on rle8_dec_pkg for field widths

interface rle8_dec_in_if;
  logic                             valid;
  logic                             ready;
  logic [rle8_dec_pkg::PIX_W-1:0]   data_byte;
  logic                             end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface rle8_dec_out_if;
  logic                             valid;
  logic                             ready;
  logic [rle8_dec_pkg::DIM_W-1:0]   start_row;
  logic [rle8_dec_pkg::DIM_W-1:0]   start_col;
  logic [rle8_dec_pkg::DIM_W-1:0]   end_row;
  logic [rle8_dec_pkg::DIM_W-1:0]   end_col;
  logic [rle8_dec_pkg::PIX_W-1:0]   pixel_value;
  logic                             clipped;
  logic                             image_done;

  modport source (output valid, output start_row, output start_col, output end_row,
                  output end_col, output pixel_value, output clipped, output image_done,
                  input ready);
  modport sink   (input valid, input start_row, input start_col, input end_row,
                  input end_col, input pixel_value, input clipped, input image_done,
                  output ready);
endinterface

interface rle8_dec_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [rle8_dec_pkg::CFG_IDX_W-1:0]    index;
  logic [rle8_dec_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

[hw/rtl/rle8_dec_parser.sv]
// rle8_dec_parser: rle8 parser state, position tracking and span generation
// depends on rle8_dec_pkg; one byte is consumed on each cycle step_i is high

module rle8_dec_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  rle8_dec_pkg::in_item_t item_i,
  input  rle8_dec_pkg::cfg_t     cfg_i,
  output logic                   span_valid_o,
  output rle8_dec_pkg::span_t    span_o
);

  localparam int unsigned DW = rle8_dec_pkg::DIM_W;
  localparam int unsigned PW = rle8_dec_pkg::PIX_W;

  localparam logic [PW-1:0] ESC_EOL   = 8'd0;
  localparam logic [PW-1:0] ESC_EOB   = 8'd1;
  localparam logic [PW-1:0] ESC_DELTA = 8'd2;

  typedef enum logic [2:0] {
    PhCount, PhRunVal, PhEscape, PhLiteral, PhPad, PhDeltaX, PhDeltaY, PhDone
  } phase_e;

  phase_e        phase_q, phase_d;
  logic [PW-1:0] held_q, held_d;
  logic [PW-1:0] lit_left_q, lit_left_d;
  logic          pad_q, pad_d;
  logic [PW-1:0] delta_q, delta_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] col_q, col_d;

  logic [DW-1:0] w, h, r, c;
  logic [PW-1:0] b, fv, lit_dec;
  logic [DW:0]   run_end, dly_row, dly_col;
  logic [DW-1:0] dly_col_clip;
  logic          dly_clip;
  logic          emit;

  always_comb begin
    if (cfg_i.image_width == '0) begin
      w = DW'(1);
    end else if (cfg_i.image_width > DW'(rle8_dec_pkg::MAX_WIDTH)) begin
      w = DW'(rle8_dec_pkg::MAX_WIDTH);
    end else begin
      w = cfg_i.image_width;
    end
    if (cfg_i.image_height == '0) begin
      h = DW'(1);
    end else if (cfg_i.image_height > DW'(rle8_dec_pkg::MAX_HEIGHT)) begin
      h = DW'(rle8_dec_pkg::MAX_HEIGHT);
    end else begin
      h = cfg_i.image_height;
    end
  end

  // position clamped to the current image size
  always_comb begin
    if (row_q >= h) begin
      r = h;
      c = '0;
    end else begin
      r = row_q;
      c = (col_q > w) ? w : col_q;
    end
  end

  assign b       = item_i.data_byte;
  assign fv      = cfg_i.fill_value;
  assign lit_dec = lit_left_q - PW'(1);
  assign run_end = (DW+1)'(c) + (DW+1)'(held_q);
  assign dly_row = (DW+1)'(r) + (DW+1)'(b);
  assign dly_col = (DW+1)'(c) + (DW+1)'(delta_q);

  always_comb begin
    phase_d    = phase_q;
    held_d     = held_q;
    lit_left_d = lit_left_q;
    pad_d      = pad_q;
    delta_d    = delta_q;
    row_d      = r;
    col_d      = c;
    emit       = 1'b0;
    span_o     = '{start_row: r, start_col: c, end_row: r, end_col: c,
                   pixel_value: fv, clipped: 1'b0, image_done: 1'b0};
    dly_col_clip = dly_col[DW-1:0];
    dly_clip     = 1'b0;

    unique case (phase_q)
      PhCount: begin
        held_d  = b;
        phase_d = (b != '0) ? PhRunVal : PhEscape;
      end
      PhRunVal: begin
        emit               = 1'b1;
        span_o.pixel_value = b;
        if (r < h) begin
          if (run_end > (DW+1)'(w)) begin
            span_o.end_col = w;
            span_o.clipped = 1'b1;
          end else begin
            span_o.end_col = run_end[DW-1:0];
          end
        end else begin
          span_o.clipped = (held_q != '0);
        end
        col_d   = span_o.end_col;
        phase_d = PhCount;
      end
      PhEscape: begin
        priority if (b == ESC_EOL) begin
          emit = 1'b1;
          if (r < h) begin
            span_o.end_row = r + DW'(1);
            span_o.end_col = '0;
          end
          row_d   = span_o.end_row;
          col_d   = span_o.end_col;
          phase_d = PhCount;
        end else if (b == ESC_EOB) begin
          emit              = 1'b1;
          span_o.end_row    = h;
          span_o.end_col    = '0;
          span_o.image_done = 1'b1;
          row_d             = h;
          col_d             = '0;
          phase_d           = PhDone;
        end else if (b == ESC_DELTA) begin
          phase_d = PhDeltaX;
        end else begin
          lit_left_d = b;
          pad_d      = b[0];
          phase_d    = PhLiteral;
        end
      end
      PhLiteral: begin
        emit               = 1'b1;
        span_o.pixel_value = b;
        if (r < h && c < w) begin
          span_o.end_col = c + DW'(1);
          col_d          = c + DW'(1);
        end else begin
          span_o.clipped = 1'b1;
        end
        lit_left_d = lit_dec;
        if (lit_dec == '0) begin
          phase_d = pad_q ? PhPad : PhCount;
        end
      end
      PhPad: begin
        pad_d   = 1'b0;
        phase_d = PhCount;
      end
      PhDeltaX: begin
        delta_d = b;
        phase_d = PhDeltaY;
      end
      PhDeltaY: begin
        emit = 1'b1;
        if (dly_col > (DW+1)'(w)) begin
          dly_col_clip = w;
          dly_clip     = 1'b1;
        end
        span_o.end_row = dly_row[DW-1:0];
        span_o.end_col = dly_col_clip;
        if (dly_row > (DW+1)'(h) || (dly_row == (DW+1)'(h) && dly_col_clip != '0)) begin
          if (r < h || b != '0 || delta_q != '0) begin
            dly_clip = 1'b1;
          end
          span_o.end_row = h;
          span_o.end_col = '0;
        end
        span_o.clipped = dly_clip;
        row_d          = span_o.end_row;
        col_d          = span_o.end_col;
        phase_d        = PhCount;
      end
      PhDone: begin
      end
      default: begin
      end
    endcase

    if (item_i.end_of_data) begin
      phase_d    = PhCount;
      held_d     = '0;
      lit_left_d = '0;
      pad_d      = 1'b0;
      delta_d    = '0;
      row_d      = '0;
      col_d      = '0;
    end
  end

  assign span_valid_o = step_i && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhCount;
      held_q     <= '0;
      lit_left_q <= '0;
      pad_q      <= 1'b0;
      delta_q    <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      held_q     <= held_d;
      lit_left_q <= lit_left_d;
      pad_q      <= pad_d;
      delta_q    <= delta_d;
      row_q      <= row_d;
      col_q      <= col_d;
    end
  end

endmodule

[hw/rtl/rle8_bitmap_decoder.sv]
// rle8_bitmap_decoder: top level of the rle8 bitmap stream decoder
// depends on rle8_dec_pkg, rle8_dec_if and rle8_dec_parser
//
// usage:
//   in_i   compressed bytes, one per transaction, end_of_data on the last one
//   out_o  raster fill spans, at most one per input byte
//   cfg_i  register writes: index 0 image_width, 1 image_height, 2 fill_value;
//          always ready, write only while no byte is in flight
// path: each accepted byte is registered in the input register, stepped through the
//   parser and its span registered in the output register; throughput: one byte per
//   cycle while out_o accepts spans, and the parser state registers update on each step
// reset: parser expects a count byte at row 0, column 0; registers return to
//   1024 x 1024 with fill value 255
// stall: while out_o.ready is low the output register holds its span and the
//   input register, if empty, still takes one more byte before in_i.ready drops

module rle8_bitmap_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  rle8_dec_in_if.sink    in_i,
  rle8_dec_out_if.source out_o,
  rle8_dec_cfg_if.sink   cfg_i
);

  logic                   in_valid_q;
  rle8_dec_pkg::in_item_t in_item_q;
  logic                   out_valid_q, out_valid_d;
  rle8_dec_pkg::span_t    out_span_q;
  rle8_dec_pkg::cfg_t     cfg_q;
  logic                   step;
  logic                   span_valid;
  rle8_dec_pkg::span_t    span;

  assign step        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q <= '{data_byte: in_i.data_byte, end_of_data: in_i.end_of_data};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{image_width:  rle8_dec_pkg::IMAGE_WIDTH_RST,
                 image_height: rle8_dec_pkg::IMAGE_HEIGHT_RST,
                 fill_value:   rle8_dec_pkg::FILL_VALUE_RST};
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rle8_dec_pkg::CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_i.wdata;
        rle8_dec_pkg::CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_i.wdata;
        rle8_dec_pkg::CFG_FILL_VALUE:   cfg_q.fill_value   <= cfg_i.wdata[rle8_dec_pkg::PIX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rle8_dec_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_item_q),
    .cfg_i        (cfg_q),
    .span_valid_o (span_valid),
    .span_o       (span)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = span_valid;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_valid) begin
      out_span_q <= span;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.start_row   = out_span_q.start_row;
  assign out_o.start_col   = out_span_q.start_col;
  assign out_o.end_row     = out_span_q.end_row;
  assign out_o.end_col     = out_span_q.end_col;
  assign out_o.pixel_value = out_span_q.pixel_value;
  assign out_o.clipped     = out_span_q.clipped;
  assign out_o.image_done  = out_span_q.image_done;

endmodule

[test/tb_rle8_bitmap_decoder.sv]
// tb_rle8_bitmap_decoder: self-checking testbench of the rle8 bitmap decoder
// drives rle8 byte streams, register writes and output stalls, predicts every fill span
// depends on rle8_dec_pkg, rle8_dec_if and rle8_bitmap_decoder

module tb_rle8_bitmap_decoder;
  import rle8_dec_pkg::*;

  localparam logic [PIX_W-1:0] ESC_EOL   = 8'd0;
  localparam logic [PIX_W-1:0] ESC_EOB   = 8'd1;
  localparam logic [PIX_W-1:0] ESC_DELTA = 8'd2;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1400;
  localparam int MAX_REPORTS  = 100;

  typedef enum logic [2:0] {
    PH_COUNT_BYTE, PH_RUN_VALUE, PH_ESCAPE, PH_LITERAL,
    PH_PAD, PH_DELTA_X, PH_DELTA_Y, PH_DONE
  } parse_phase_e;

  class span_scoreboard;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [PIX_W-1:0] fill_reg;
    parse_phase_e     phase;
    logic [7:0]       count_byte;
    logic [7:0]       literals_left;
    logic [7:0]       delta_cols;
    logic             pad_pending;
    int unsigned      row;
    int unsigned      col;
    span_t            expected_q[$];
    int unsigned      fails;

    function new();
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      fill_reg   = FILL_VALUE_RST;
      fails      = 0;
      restart();
    endfunction

    function void restart();
      phase         = PH_COUNT_BYTE;
      count_byte    = '0;
      literals_left = '0;
      delta_cols    = '0;
      pad_pending   = 1'b0;
      row           = 0;
      col           = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg  = data;
        CFG_IMAGE_HEIGHT: height_reg = data;
        CFG_FILL_VALUE:   fill_reg   = data[PIX_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned usable_dim(logic [DIM_W-1:0] v, int unsigned limit);
      int unsigned d;
      d = v;
      if (d == 0) d = 1;
      if (d > limit) d = limit;
      return d;
    endfunction

    function void push_span(int unsigned sr, int unsigned sc, int unsigned er,
                            int unsigned ec, logic [PIX_W-1:0] val, logic clip, logic done);
      span_t s;
      s.start_row   = DIM_W'(sr);
      s.start_col   = DIM_W'(sc);
      s.end_row     = DIM_W'(er);
      s.end_col     = DIM_W'(ec);
      s.pixel_value = val;
      s.clipped     = clip;
      s.image_done  = done;
      expected_q.push_back(s);
    endfunction

    // one accepted byte: advance the parser and queue the span it causes
    function void note_byte(logic [PIX_W-1:0] b, logic eod);
      int unsigned w, h, r, c, tr, tc;
      logic clip;
      w = usable_dim(width_reg, MAX_WIDTH);
      h = usable_dim(height_reg, MAX_HEIGHT);
      if (row >= h) begin
        row = h;
        col = 0;
      end
      if (col > w) col = w;
      r = row;
      c = col;
      case (phase)
        PH_COUNT_BYTE: begin
          count_byte = b;
          phase = (b != 0) ? PH_RUN_VALUE : PH_ESCAPE;
        end
        PH_RUN_VALUE: begin
          tc = c;
          clip = 1'b0;
          if (r < h) begin
            tc = c + count_byte;
            if (tc > w) begin
              tc = w;
              clip = 1'b1;
            end
          end else if (count_byte != 0) begin
            clip = 1'b1;
          end
          push_span(r, c, r, tc, b, clip, 1'b0);
          col = tc;
          phase = PH_COUNT_BYTE;
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            tr = r;
            tc = c;
            if (r < h) begin
              tr = r + 1;
              tc = 0;
            end
            push_span(r, c, tr, tc, fill_reg, 1'b0, 1'b0);
            row = tr;
            col = tc;
            phase = PH_COUNT_BYTE;
          end else if (b == ESC_EOB) begin
            push_span(r, c, h, 0, fill_reg, 1'b0, 1'b1);
            row = h;
            col = 0;
            phase = PH_DONE;
          end else if (b == ESC_DELTA) begin
            phase = PH_DELTA_X;
          end else begin
            literals_left = b;
            pad_pending = b[0];
            phase = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          if (r < h && c < w) begin
            push_span(r, c, r, c + 1, b, 1'b0, 1'b0);
            col = c + 1;
          end else begin
            push_span(r, c, r, c, b, 1'b1, 1'b0);
          end
          literals_left = literals_left - 8'd1;
          if (literals_left == 0) phase = pad_pending ? PH_PAD : PH_COUNT_BYTE;
        end
        PH_PAD: begin
          pad_pending = 1'b0;
          phase = PH_COUNT_BYTE;
        end
        PH_DELTA_X: begin
          delta_cols = b;
          phase = PH_DELTA_Y;
        end
        PH_DELTA_Y: begin
          clip = 1'b0;
          tr = r + b;
          tc = c + delta_cols;
          if (tc > w) begin
            tc = w;
            clip = 1'b1;
          end
          if (tr > h || (tr == h && tc > 0)) begin
            if (r < h || b != 0 || delta_cols != 0) clip = 1'b1;
            tr = h;
            tc = 0;
          end
          push_span(r, c, tr, tc, fill_reg, clip, 1'b0);
          row = tr;
          col = tc;
          phase = PH_COUNT_BYTE;
        end
        default: ;
      endcase
      if (eod) restart();
    endfunction

    function string show(span_t s);
      return $sformatf("(%0d,%0d)->(%0d,%0d) val %0d clip %0b done %0b", s.start_row,
                       s.start_col, s.end_row, s.end_col, s.pixel_value, s.clipped,
                       s.image_done);
    endfunction

    task report(string msg);
      fails++;
      if (fails <= MAX_REPORTS) $display("span check failed: %s", msg);
    endtask

    task check_span(span_t got);
      span_t want;
      if (expected_q.size() == 0) begin
        report({"unexpected span ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) report({"got ", show(got), ", expected ", show(want)});
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rle8_dec_in_if  in_if ();
  rle8_dec_out_if out_if ();
  rle8_dec_cfg_if cfg_if ();

  rle8_bitmap_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  span_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned gen_w;
  int unsigned gen_h;
  int unsigned counted;
  logic [8:0]  stream_q[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5000000;
    $display("TB_ERROR");
    $finish;
  end

  // transaction monitor: results first, then register writes, then bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check_span('{start_row: out_if.start_row, start_col: out_if.start_col,
                        end_row: out_if.end_row, end_col: out_if.end_col,
                        pixel_value: out_if.pixel_value, clipped: out_if.clipped,
                        image_done: out_if.image_done});
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.wdata);
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.end_of_data);
    end
  end

  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void put(logic [7:0] b, logic eod = 1'b0);
    stream_q.push_back({eod, b});
    counted++;
  endfunction

  function automatic void add_run();
    int unsigned cap;
    cap = (gen_w + 2 > 255) ? 255 : gen_w + 2;
    put(8'($urandom_range(9) == 0 ? $urandom_range(255, 1) : $urandom_range(cap, 1)));
    put(8'($urandom));
  endfunction

  function automatic void add_literal();
    int unsigned n;
    n = ($urandom_range(49) == 0) ? $urandom_range(255, 3) : $urandom_range(10, 3);
    put(8'h00);
    put(8'(n));
    repeat (n) put(8'($urandom));
    if (n % 2 == 1) put(8'($urandom));
  endfunction

  function automatic void add_delta();
    int unsigned cap;
    cap = (gen_w > 255) ? 255 : gen_w;
    put(8'h00);
    put(ESC_DELTA);
    put(8'($urandom_range(4) == 0 ? $urandom_range(255) : $urandom_range(cap)));
    put(8'($urandom_range(4) == 0 ? $urandom_range(255) : $urandom_range(1)));
  endfunction

  // mostly well-formed bitmaps with random content, some noise and cut-off streams
  function automatic void build_bitmap();
    int unsigned ncmd, kind, ending, extra;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(30, 5)) put(8'($urandom));
      stream_q[stream_q.size()-1][8] = 1'b1;
      return;
    end
    ncmd = $urandom_range(16, 2);
    for (int i = 0; i < ncmd; i++) begin
      kind = $urandom_range(99);
      if (kind < 40) add_run();
      else if (kind < 60) add_literal();
      else if (kind < 78) begin
        put(8'h00);
        put(ESC_EOL);
      end else if (kind < 92) add_delta();
      else put(8'($urandom));
    end
    ending = $urandom_range(99);
    if (ending < 75) begin
      put(8'h00);
      if (ending < 15) begin
        put(ESC_EOB, 1'b1);
      end else begin
        put(ESC_EOB);
        extra = $urandom_range(3);
        repeat (extra) stream_q.push_back({1'b0, 8'($urandom)});
        stream_q.push_back({1'b1, 8'($urandom)});
      end
    end else if (ending < 90) begin
      stream_q[stream_q.size()-1][8] = 1'b1;
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic eod);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.end_of_data <= eod;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_stream();
    logic [8:0] item;
    while (stream_q.size() != 0) begin
      item = stream_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic configure(int unsigned w, int unsigned h, int unsigned f);
    wait_idle();
    cfg_write(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
    cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_write(CFG_FILL_VALUE, CFG_DATA_W'(f));
    cfg_if.valid <= 1'b0;
    gen_w = (w == 0) ? 1 : (w > MAX_WIDTH ? MAX_WIDTH : w);
    gen_h = (h == 0) ? 1 : (h > MAX_HEIGHT ? MAX_HEIGHT : h);
  endtask

  function automatic int unsigned pick_width();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 1;
    if (r < 30) return MAX_WIDTH;
    if (r < 35) return 0;
    if (r < 38) return 2047;
    return $urandom_range(40, 2);
  endfunction

  function automatic int unsigned pick_height();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 1;
    if (r < 25) return MAX_HEIGHT;
    if (r < 28) return 0;
    return $urandom_range(12, 1);
  endfunction

  function automatic int unsigned pick_fill();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 20) return 0;
    if (r < 40) return 255;
    return $urandom_range(255);
  endfunction

  initial begin
    int unsigned idle_sched[4];
    int unsigned stall_sched[4];
    idle_sched  = '{0, 75, 0, 35};
    stall_sched = '{0, 0, 75, 35};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_w   = MAX_WIDTH;
    gen_h   = MAX_HEIGHT;
    counted = 0;
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.data_byte   <= '0;
    in_if.end_of_data <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= CFG_IMAGE_WIDTH;
    cfg_if.wdata      <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes, end of data without end of bitmap
    put(8'hFF); put(8'h80, 1'b1);
    send_stream();

    configure(6, 3, 0);
    put(8'hFF); put(8'hFF);                           // run past row end
    put(8'h00); put(8'h03); put(8'h11); put(8'h22); put(8'h33); // literals past row end
    put(8'h7E);                                       // pad byte
    put(8'h00); put(ESC_EOL);
    put(8'h00); put(ESC_DELTA); put(8'h05); put(8'h01); // delta inside the image
    put(8'h00); put(ESC_DELTA); put(8'h00); put(8'hFF); // delta past image end
    put(8'h02); put(8'h44);                           // run beyond the image
    put(8'h00); put(ESC_EOL);                         // empty end of line
    put(8'h00); put(ESC_EOB);
    stream_q.push_back({1'b0, 8'h5A});                // ignored after end of bitmap
    stream_q.push_back({1'b1, 8'h00});
    send_stream();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_sched[p];
      recv_stall_pct = stall_sched[p];
      case (p)
        0: configure(MAX_WIDTH, MAX_HEIGHT, 255);
        1: configure(1, 1, 0);
        2: configure(2047, 0, 128);
        default: configure(pick_width(), pick_height(), pick_fill());
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS / 4) begin
        if ($urandom_range(3) == 0) configure(pick_width(), pick_height(), pick_fill());
        build_bitmap();
        send_stream();
      end
    end

    wait_idle();
    if (sb.fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
